FILE: hdl/apsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package apsc_pkg;

   // Tick width of the step timer; the sample time port is always 32 bits.
   localparam int TICK_BITS_DEFAULT = 32;

   // Entries in the queue between the classifier and the step machine.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Register reset values.
   localparam logic [15:0] GRAVITY_LEVEL_RESET = 16'd16384;
   localparam logic [15:0] RISE_THRESHOLD_RESET = 16'd2000;
   localparam logic [31:0] MIN_INTERVAL_RESET = 32'd300;

   // Register indexes on the csr port.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRAVITY_LEVEL = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RISE_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_INTERVAL = 2'd2;

   // Request modes.
   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_CLEAR = 1'b1;

   typedef struct packed {
      logic [15:0] gravity_level;
      logic [15:0] rise_threshold;
      logic [31:0] min_interval;
   } cfg_type;

   // One classified request as it waits for the step machine.
   typedef struct packed {
      logic        clear;
      logic        above;
      logic        below;
      logic [31:0] sample_time;
   } work_type;

endpackage

`default_nettype wire

FILE: hdl/apsc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module apsc_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic                req_mode,
   input  wire logic signed [15:0]  req_accel_x,
   input  wire logic signed [15:0]  req_accel_y,
   input  wire logic signed [15:0]  req_accel_z,
   input  wire logic [31:0]         req_sample_time,
   input  wire apsc_pkg::cfg_type   cfg,
   output logic                     work_valid,
   output apsc_pkg::work_type       work
);
   import apsc_pkg::*;

   logic signed [31:0] prod_x;
   logic signed [31:0] prod_y;
   logic signed [31:0] prod_z;
   logic [16:0]        hi_level;

   // Stage one: squares of the three axes and of both thresholds.
   logic [30:0] sq_x_ff, sq_x_in;
   logic [30:0] sq_y_ff, sq_y_in;
   logic [30:0] sq_z_ff, sq_z_in;
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_mode_ff;
   logic [31:0] s1_time_ff;
   logic [33:0] hi_sq_ff, hi_sq_in;
   logic [31:0] lo_sq_ff, lo_sq_in;

   // Stage two: classified request.
   logic [31:0] mag_sq;
   logic        work_valid_ff, work_valid_in;
   work_type    work_ff, work_in;

   always_comb begin
      prod_x = req_accel_x * req_accel_x;
      prod_y = req_accel_y * req_accel_y;
      prod_z = req_accel_z * req_accel_z;
      sq_x_in = prod_x[30:0];
      sq_y_in = prod_y[30:0];
      sq_z_in = prod_z[30:0];
      s1_valid_in = accept;
      hi_level = 17'(cfg.gravity_level) + 17'(cfg.rise_threshold);
      hi_sq_in = 34'(hi_level) * 34'(hi_level);
      lo_sq_in = 32'(cfg.gravity_level) * 32'(cfg.gravity_level);
   end

   always_comb begin
      // Three squares of at most 2^30 each fit in 32 bits.
      mag_sq = 32'(sq_x_ff) + 32'(sq_y_ff) + 32'(sq_z_ff);
      work_valid_in = s1_valid_ff;
      work_in.clear = (s1_mode_ff == MODE_CLEAR);
      work_in.above = (34'(mag_sq) > hi_sq_ff);
      work_in.below = (mag_sq < lo_sq_ff);
      work_in.sample_time = s1_time_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         work_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         work_valid_ff <= work_valid_in;
      end
      sq_x_ff <= sq_x_in;
      sq_y_ff <= sq_y_in;
      sq_z_ff <= sq_z_in;
      s1_mode_ff <= req_mode;
      s1_time_ff <= req_sample_time;
      hi_sq_ff <= hi_sq_in;
      lo_sq_ff <= lo_sq_in;
      work_ff <= work_in;
   end

   assign work_valid = work_valid_ff;
   assign work = work_ff;

endmodule

`default_nettype wire

FILE: hdl/apsc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module apsc_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire apsc_pkg::work_type push_work,
   input  wire logic               pop,
   output logic                    head_valid,
   output apsc_pkg::work_type      head_work
);
   import apsc_pkg::*;

   work_type                    slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;

   function automatic logic [QUEUE_PTR_BITS-1:0] next_ptr(
      input logic [QUEUE_PTR_BITS-1:0] ptr
   );
      if (ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   // The upstream credit count keeps pushes from ever meeting a full queue.
   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff + QUEUE_COUNT_BITS'(push) - QUEUE_COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_work;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_work = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

FILE: hdl/apsc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module apsc_back #(
   parameter int TICK_BITS = apsc_pkg::TICK_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  wire apsc_pkg::work_type head_work,
   output logic                    pop,
   input  wire apsc_pkg::cfg_type  cfg,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [31:0]             rsp_steps_total,
   output logic                    rsp_step_seen,
   output logic                    rsp_armed
);
   import apsc_pkg::*;

   localparam int WIDE_BITS = TICK_BITS + 32;

   typedef enum logic {
      PHASE_PEAK,
      PHASE_TROUGH
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [TICK_BITS-1:0]   last_ff, last_in;
   logic [31:0]            total_ff, total_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_total_ff;
   logic                   rsp_seen_ff, rsp_seen_in;
   logic                   rsp_armed_ff;

   logic [WIDE_BITS-1:0]   time_wide;
   logic [TICK_BITS-1:0]   now;
   logic [TICK_BITS-1:0]   gap;
   logic                   gap_ok;

   always_comb begin
      pop = head_valid && (!rsp_valid_ff || !rsp_stall);

      time_wide = WIDE_BITS'(head_work.sample_time);
      now = time_wide[TICK_BITS-1:0];
      gap = now - last_ff;
      gap_ok = WIDE_BITS'(gap) > WIDE_BITS'(cfg.min_interval);

      phase_in = phase_ff;
      last_in = last_ff;
      total_in = total_ff;
      rsp_seen_in = 1'b0;
      if (head_work.clear) begin
         total_in = '0;
      end else begin
         unique case (phase_ff)
            PHASE_PEAK: begin
               if (head_work.above) begin
                  phase_in = PHASE_TROUGH;
               end
            end
            PHASE_TROUGH: begin
               if (head_work.below) begin
                  phase_in = PHASE_PEAK;
                  if (gap_ok) begin
                     total_in = total_ff + 32'd1;
                     last_in = now;
                     rsp_seen_in = 1'b1;
                  end
               end
            end
            default: begin
               phase_in = PHASE_PEAK;
            end
         endcase
      end

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_PEAK;
         last_ff <= '0;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff <= phase_in;
            last_ff <= last_in;
            total_ff <= total_in;
         end
      end
      if (pop) begin
         rsp_total_ff <= total_in;
         rsp_seen_ff <= rsp_seen_in;
         rsp_armed_ff <= (phase_in == PHASE_TROUGH);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_steps_total = rsp_total_ff;
   assign rsp_step_seen = rsp_seen_ff;
   assign rsp_armed = rsp_armed_ff;

endmodule

`default_nettype wire

FILE: hdl/accel_peak_trough_step_counter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  mode, accel_x/y/z, sample_time
// rsp       out        rsp_valid/rsp_stall  steps_total, step_seen, armed
// csr       in         csr_write            csr_index, csr_wdata (no read-back)
//
// One request is taken per cycle while req_stall is low, and each request
// yields exactly one response. A request passes through the squares register,
// the threshold compare register and the work queue; the step machine then
// updates its state and loads the response register when it takes the request,
// which waits while the response register is held by rsp_stall.
// Reset is synchronous and restores the register defaults and the idle state.
// req_stall rises only when the queue and classifier hold four requests that
// the step machine has not yet taken, which happens only under rsp_stall.

module accel_peak_trough_step_counter_unit #(
   parameter int TICK_BITS = apsc_pkg::TICK_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_mode,
   input  wire logic signed [15:0]                    req_accel_x,
   input  wire logic signed [15:0]                    req_accel_y,
   input  wire logic signed [15:0]                    req_accel_z,
   input  wire logic [31:0]                           req_sample_time,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [31:0]                                rsp_steps_total,
   output logic                                       rsp_step_seen,
   output logic                                       rsp_armed,
   input  wire logic                                  csr_write,
   input  wire logic [apsc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [31:0]                           csr_wdata
);
   import apsc_pkg::*;

   // Configuration registers. Writes to unused indexes are dropped.
   cfg_type cfg_ff, cfg_in;

   // Requests accepted but not yet taken from the queue by the step machine.
   // Bounding this by the queue depth keeps the queue from overflowing while
   // the classifier itself never stalls.
   logic [QUEUE_COUNT_BITS-1:0] inflight_ff, inflight_in;

   logic     accept;
   logic     work_valid;
   work_type work;
   logic     head_valid;
   work_type head_work;
   logic     pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_GRAVITY_LEVEL:  cfg_in.gravity_level = csr_wdata[15:0];
            CSR_RISE_THRESHOLD: cfg_in.rise_threshold = csr_wdata[15:0];
            CSR_MIN_INTERVAL:   cfg_in.min_interval = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   assign req_stall = (inflight_ff == QUEUE_COUNT_BITS'(QUEUE_DEPTH));
   assign accept = req_valid && !req_stall;

   always_comb begin
      inflight_in = inflight_ff + QUEUE_COUNT_BITS'(accept) - QUEUE_COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gravity_level <= GRAVITY_LEVEL_RESET;
         cfg_ff.rise_threshold <= RISE_THRESHOLD_RESET;
         cfg_ff.min_interval <= MIN_INTERVAL_RESET;
         inflight_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
         inflight_ff <= inflight_in;
      end
   end

   // The classifier squares the axes and compares the squared magnitude with
   // the squared thresholds, so no square root is ever taken.
   apsc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_mode        (req_mode),
      .req_accel_x     (req_accel_x),
      .req_accel_y     (req_accel_y),
      .req_accel_z     (req_accel_z),
      .req_sample_time (req_sample_time),
      .cfg             (cfg_ff),
      .work_valid      (work_valid),
      .work            (work)
   );

   apsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (work_valid),
      .push_work  (work),
      .pop        (pop),
      .head_valid (head_valid),
      .head_work  (head_work)
   );

   // The step machine holds the phase, the last step tick and the count, and
   // owns the response register.
   apsc_back #(
      .TICK_BITS (TICK_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_work       (head_work),
      .pop             (pop),
      .cfg             (cfg_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_steps_total (rsp_steps_total),
      .rsp_step_seen   (rsp_step_seen),
      .rsp_armed       (rsp_armed)
   );

endmodule

`default_nettype wire

FILE: bench/accel_peak_trough_step_counter_unit_test.sv
`timescale 1ns / 1ps

// The bench keeps its own copy of the step counter state and of the thresholds.
// On every accepted request it works out the response that the block must give.
// Responses come back in request order, one per request, so the expected values
// wait in a FIFO and each accepted response is checked against the oldest one.

module accel_peak_trough_step_counter_unit_test;

   import apsc_pkg::*;

   // One request as the bench sees it. Its fields have the widths of the ports.
   typedef struct packed {
      logic               mode;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic [31:0]        tick;
   } accel_request_type;

   // One response: the running count, the new-step flag and the phase.
   typedef struct packed {
      logic [31:0] steps_total;
      logic        step_seen;
      logic        armed;
   } step_report_type;

   // A row of the directed walk. When pinned is set, the response is written out
   // in the row. Otherwise the tracker below supplies it.
   typedef struct packed {
      accel_request_type request;
      logic              pinned;
      step_report_type   want;
   } walk_row_type;

   // These are the shapes of random samples. A peak lies above gravity plus the
   // rise, and a trough lies below gravity. A level sample sits on gravity,
   // capped at 32767, and below the cap it is neither a peak nor a trough.
   typedef enum logic [2:0] {
      SHAPE_PEAK,
      SHAPE_TROUGH,
      SHAPE_LEVEL,
      SHAPE_NOISE,
      SHAPE_CLEAR
   } shape_type;

   // This index has no register behind it. A write to it must change nothing.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_mode = MODE_SAMPLE;
   logic signed [15:0] req_accel_x = '0;
   logic signed [15:0] req_accel_y = '0;
   logic signed [15:0] req_accel_z = '0;
   logic [31:0]        req_sample_time = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [31:0]        rsp_steps_total;
   logic               rsp_step_seen;
   logic               rsp_armed;
   logic               csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_GRAVITY_LEVEL;
   logic [31:0]        csr_wdata = '0;

   // This is the tracked state of the step counter and its thresholds.
   cfg_type     track_cfg;
   logic        track_armed;
   logic [31:0] track_last_tick;
   logic [31:0] track_steps;

   step_report_type step_reports_due [$];
   int              mismatches = 0;
   int              idle_pct = 31;
   logic [31:0]     next_tick = '0;

   // The walk starts from the reset thresholds: gravity 16384, rise 2000 and an
   // interval of 300. With these, a peak needs a magnitude above 18384.
   walk_row_type walk_rows [0:19] = '{
      // A sample at rest just after reset reports all zeros.
      '{'{MODE_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 32'd0}, 1'b1, '{32'd0, 1'b0, 1'b0}},
      // Full negative scale on all three axes arms the machine.
      '{'{MODE_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 32'd100}, 1'b1, '{32'd0, 1'b0, 1'b1}},
      // This trough comes too soon after tick zero, so it disarms without a step.
      '{'{MODE_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 32'd200}, 1'b0, '0},
      '{'{MODE_SAMPLE, 16'h7FFF, 16'h0000, 16'h0000, 32'd1000}, 1'b1, '{32'd0, 1'b0, 1'b1}},
      // A magnitude of exactly gravity is not below it, so the machine stays armed.
      '{'{MODE_SAMPLE, 16'd16384, 16'h0000, 16'h0000, 32'd1000}, 1'b0, '0},
      '{'{MODE_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 32'd1000}, 1'b0, '0},
      '{'{MODE_SAMPLE, 16'h8000, 16'h0000, 16'h0000, 32'd1200}, 1'b0, '0},
      // A clear zeroes the count, keeps the phase and ignores the sample fields.
      '{'{MODE_CLEAR, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF}, 1'b1,
        '{32'd0, 1'b0, 1'b1}},
      // A gap of exactly the interval is not enough to count a step.
      '{'{MODE_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 32'd1300}, 1'b0, '0},
      // A magnitude of exactly gravity plus the rise does not arm.
      '{'{MODE_SAMPLE, 16'd18384, 16'h0000, 16'h0000, 32'd1300}, 1'b0, '0},
      '{'{MODE_SAMPLE, 16'h0000, 16'd18385, 16'h0000, 32'd1300}, 1'b0, '0},
      '{'{MODE_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 32'd1301}, 1'b0, '0},
      '{'{MODE_SAMPLE, 16'h8000, 16'h7FFF, 16'h8000, 32'd5000}, 1'b0, '0},
      '{'{MODE_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF}, 1'b0, '0},
      '{'{MODE_SAMPLE, 16'h0000, 16'h0000, 16'h7FFF, 32'd0}, 1'b0, '0},
      // The tick wraps past zero. The gap is 401, so this trough counts.
      '{'{MODE_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 32'd400}, 1'b0, '0},
      '{'{MODE_SAMPLE, 16'h8000, 16'h8000, 16'h7FFF, 32'd500}, 1'b0, '0},
      '{'{MODE_SAMPLE, 16'h0000, 16'hC001, 16'h0000, 32'd600}, 1'b0, '0},
      '{'{MODE_CLEAR, 16'h5555, 16'hAAAA, 16'h0F0F, 32'h1234_5678}, 1'b1,
        '{32'd0, 1'b0, 1'b0}},
      '{'{MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000, 32'd0}, 1'b1, '{32'd0, 1'b0, 1'b0}}
   };

   accel_peak_trough_step_counter_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_accel_x     (req_accel_x),
      .req_accel_y     (req_accel_y),
      .req_accel_z     (req_accel_z),
      .req_sample_time (req_sample_time),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_steps_total (rsp_steps_total),
      .rsp_step_seen   (rsp_step_seen),
      .rsp_armed       (rsp_armed),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   // This function advances the tracked step counter by one request and returns
   // the response that the request must produce. Squares are summed in 64 bits,
   // and thresholds are squared instead of taking a root. The tick gap wraps at
   // 32 bits.
   function automatic step_report_type advance_step_counter(input accel_request_type r);
      longint            sx;
      longint            sy;
      longint            sz;
      longint unsigned   mag_sq;
      longint unsigned   peak_sq;
      longint unsigned   trough_sq;
      logic [31:0]       gap;
      step_report_type   report;
      report.step_seen = 1'b0;
      if (r.mode == MODE_CLEAR) begin
         track_steps = '0;
      end else begin
         sx = r.x;
         sy = r.y;
         sz = r.z;
         mag_sq = longint'(sx * sx + sy * sy + sz * sz);
         peak_sq = longint'(track_cfg.gravity_level) + longint'(track_cfg.rise_threshold);
         peak_sq = peak_sq * peak_sq;
         trough_sq = longint'(track_cfg.gravity_level) * longint'(track_cfg.gravity_level);
         if (!track_armed) begin
            if (mag_sq > peak_sq) begin
               track_armed = 1'b1;
            end
         end else if (mag_sq < trough_sq) begin
            gap = r.tick - track_last_tick;
            if (gap > track_cfg.min_interval) begin
               track_steps = track_steps + 32'd1;
               track_last_tick = r.tick;
               report.step_seen = 1'b1;
            end
            track_armed = 1'b0;
         end
      end
      report.steps_total = track_steps;
      report.armed = track_armed;
      return report;
   endfunction

   function automatic logic signed [15:0] signed_axis(input int lo_mag, input int hi_mag);
      int mag;
      mag = $urandom_range(hi_mag, lo_mag);
      return 16'($urandom_range(1) ? -mag : mag);
   endfunction

   // This function builds a random request of the given shape. The ticks move on
   // by up to about twice the interval, taken as at most 1000, so steps land on
   // both sides of the interval, and now and then the tick jumps to a random
   // value. The peak floor gives each axis 0.6 of the arming level, capped at
   // 32767, so the peak sum lies above the arming level unless the cap applies.
   // The trough ceiling, half of gravity per axis, keeps the sum below any nonzero gravity.
   function automatic accel_request_type shape_request(input shape_type shape);
      accel_request_type r;
      int                peak_floor;
      int                trough_top;
      int                level;
      int                stride;
      peak_floor = (int'(track_cfg.gravity_level) + int'(track_cfg.rise_threshold)) * 6 / 10 + 1;
      if (peak_floor > 32767) begin
         peak_floor = 32767;
      end
      trough_top = int'(track_cfg.gravity_level) / 2;
      level = (track_cfg.gravity_level > 16'd32767) ? 32767 : int'(track_cfg.gravity_level);
      stride = (track_cfg.min_interval > 32'd1000) ? 1000 : int'(track_cfg.min_interval);
      if ($urandom_range(99) < 4) begin
         next_tick = $urandom;
      end else begin
         next_tick = next_tick + 32'($urandom_range(2 * stride + 2));
      end
      r.mode = MODE_SAMPLE;
      r.tick = next_tick;
      case (shape)
         SHAPE_PEAK: begin
            r.x = signed_axis(peak_floor, 32767);
            r.y = signed_axis(peak_floor, 32767);
            r.z = signed_axis(peak_floor, 32767);
         end
         SHAPE_TROUGH: begin
            r.x = signed_axis(0, trough_top);
            r.y = signed_axis(0, trough_top);
            r.z = signed_axis(0, trough_top);
         end
         SHAPE_LEVEL: begin
            r.x = signed_axis(level, level);
            r.y = '0;
            r.z = '0;
         end
         default: begin
            r.x = 16'($urandom);
            r.y = 16'($urandom);
            r.z = 16'($urandom);
            r.tick = $urandom;
            if (shape == SHAPE_CLEAR) begin
               r.mode = MODE_CLEAR;
            end
         end
      endcase
      return r;
   endfunction

   // This task offers one request after a random number of idle cycles and holds
   // it until it is taken. When the request is accepted, its expected response
   // is queued.
   task automatic send_request(input accel_request_type r, input logic pinned,
                               input step_report_type want);
      step_report_type due;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= r.mode;
      req_accel_x <= r.x;
      req_accel_y <= r.y;
      req_accel_z <= r.z;
      req_sample_time <= r.tick;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      due = advance_step_counter(r);
      step_reports_due.push_back(pinned ? want : due);
   endtask

   // Most random requests follow the peak and trough rhythm that the tracked
   // phase expects next. The rest are level samples, noise and clears, which
   // break that rhythm.
   task automatic run_random(input int count);
      accel_request_type r;
      int                roll;
      shape_type         shape;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 3) begin
            shape = SHAPE_CLEAR;
         end else if (roll < 18) begin
            shape = SHAPE_NOISE;
         end else if (roll < 26) begin
            shape = SHAPE_LEVEL;
         end else begin
            shape = track_armed ? SHAPE_TROUGH : SHAPE_PEAK;
         end
         r = shape_request(shape);
         send_request(r, 1'b0, '0);
      end
   endtask

   // This task stops sending, waits for every outstanding response, and then
   // lets the clock run on while the pipeline drains.
   task automatic settle();
      req_valid <= 1'b0;
      while (step_reports_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   // This task writes all three thresholds. The upper half of a 16-bit register's
   // write data is random and must be dropped. When poke_spare is set, a write to
   // the unused index follows, and the block must ignore it.
   task automatic configure(input logic [15:0] gravity, input logic [15:0] rise,
                            input logic [31:0] interval, input logic poke_spare);
      logic [31:0] data;
      data = {16'($urandom), gravity};
      csr_write <= 1'b1;
      csr_index <= CSR_GRAVITY_LEVEL;
      csr_wdata <= data;
      @(posedge clock);
      track_cfg.gravity_level = data[15:0];
      data = {16'($urandom), rise};
      csr_index <= CSR_RISE_THRESHOLD;
      csr_wdata <= data;
      @(posedge clock);
      track_cfg.rise_threshold = data[15:0];
      csr_index <= CSR_MIN_INTERVAL;
      csr_wdata <= interval;
      @(posedge clock);
      track_cfg.min_interval = interval;
      if (poke_spare) begin
         csr_index <= CSR_SPARE;
         csr_wdata <= $urandom;
         @(posedge clock);
      end
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // The bench stalls the response channel at random, with a chance of idle_pct
   // percent, 31 by default. It never stalls while idle_pct is zero.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   // Every response that is accepted must match the oldest expectation in every
   // field.
   always @(posedge clock) begin : check_responses
      step_report_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (step_reports_due.size() == 0) begin
            $display("%0t: response with nothing expected: steps_total %0d seen %0b armed %0b",
                     $time, rsp_steps_total, rsp_step_seen, rsp_armed);
            mismatches++;
         end else begin
            due = step_reports_due.pop_front();
            if (rsp_steps_total !== due.steps_total) begin
               $display("%0t: steps_total expected %0d, got %0d",
                        $time, due.steps_total, rsp_steps_total);
               mismatches++;
            end
            if (rsp_step_seen !== due.step_seen) begin
               $display("%0t: step_seen expected %0b, got %0b",
                        $time, due.step_seen, rsp_step_seen);
               mismatches++;
            end
            if (rsp_armed !== due.armed) begin
               $display("%0t: armed expected %0b, got %0b", $time, due.armed, rsp_armed);
               mismatches++;
            end
         end
      end
   end

   initial begin
      track_cfg.gravity_level = GRAVITY_LEVEL_RESET;
      track_cfg.rise_threshold = RISE_THRESHOLD_RESET;
      track_cfg.min_interval = MIN_INTERVAL_RESET;
      track_armed = 1'b0;
      track_last_tick = '0;
      track_steps = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The directed walk runs against the reset thresholds.
      foreach (walk_rows[i]) begin
         send_request(walk_rows[i].request, walk_rows[i].pinned, walk_rows[i].want);
      end
      settle();

      // Random traffic still runs with the reset thresholds.
      run_random(300);
      settle();

      // Typical thresholds follow, and the spare index gets a write. In this
      // stretch neither side idles.
      configure(16'($urandom_range(24000, 8000)), 16'($urandom_range(6000, 0)),
                32'($urandom_range(800, 0)), 1'b1);
      idle_pct = 0;
      run_random(300);
      settle();
      idle_pct = 31;

      // With every threshold at zero, any nonzero magnitude arms the machine and
      // nothing can disarm it.
      configure(16'd0, 16'd0, 32'd0, 1'b0);
      run_random(80);
      settle();

      // With every threshold at full scale, nothing can arm the machine.
      configure(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      run_random(80);
      settle();

      // With no rise or interval, a trough after a peak counts on any nonzero gap.
      configure(16'd30000, 16'd0, 32'd0, 1'b0);
      run_random(300);
      settle();

      // With the interval at full scale, no gap can be large enough to count.
      configure(16'($urandom_range(24000, 8000)), 16'($urandom_range(6000, 0)),
                32'hFFFF_FFFF, 1'b0);
      run_random(120);
      settle();

      configure(16'($urandom_range(24000, 8000)), 16'($urandom_range(6000, 0)),
                32'($urandom_range(800, 0)), 1'b1);
      run_random(500);
      settle();

      if (mismatches == 0) begin
         $display("accel_peak_trough_step_counter_unit_test: done, clean");
      end else begin
         $display("accel_peak_trough_step_counter_unit_test: done, errors");
      end
      $finish;
   end

   // This limit lies far above the length of a correct run.
   initial begin
      #400000;
      $display("accel_peak_trough_step_counter_unit_test: done, errors");
      $finish;
   end

endmodule
